// ===== rtl/core/iso2ep_pkg.sv =====
// Shared types, constants and tables for the ISO timestamp to epoch converter.
// No dependencies; imported by iso2ep_ctrl, iso2ep_dp and the top level.
package iso2ep_pkg;

  // Field widths
  localparam int unsigned CharW  = 8;
  localparam int unsigned PosW   = 5;
  localparam int unsigned YearW  = 14;
  localparam int unsigned FieldW = 7;
  localparam int unsigned EpochW = 39;

  // Text layout of YYYY-MM-DDTHH:MM:SS
  localparam logic [PosW-1:0] FullLen  = 5'd19;
  localparam logic [PosW-1:0] PosDashY = 5'd4;
  localparam logic [PosW-1:0] PosDashM = 5'd7;
  localparam logic [PosW-1:0] PosSep   = 5'd10;
  localparam logic [PosW-1:0] PosColH  = 5'd13;
  localparam logic [PosW-1:0] PosColM  = 5'd16;

  // Characters
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChDash  = 8'h2D;
  localparam logic [CharW-1:0] ChColon = 8'h3A;
  localparam logic [CharW-1:0] ChUpT   = 8'h54;
  localparam logic [CharW-1:0] ChLowT  = 8'h74;
  localparam logic [CharW-1:0] ChSpace = 8'h20;

  // Calendar constants
  localparam logic [12:0] EraRecip   = 13'd5243;  // ceil(2^21 / 400)
  localparam int unsigned EraShift   = 21;

  // Controller states
  typedef enum logic [2:0] {
    ST_PARSE,
    ST_ERA,
    ST_YOE,
    ST_DOE,
    ST_DAYS,
    ST_TOTAL,
    ST_HOLD
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic take;      // accept one character beat into the parser
    logic load;      // final character: latch fields, clear parser
    logic era;       // shifted year and era
    logic yoe;       // year of era, day of year
    logic doe;       // day of era, second of day
    logic days;      // days since 1970
    logic total;     // seconds since 1970
    logic out_load;  // move result into the output register
  } cmd_t;

  // Days before the start of a March-based month: (153 * mp + 2) / 5
  function automatic logic [8:0] month_base(input logic [3:0] mp);
    logic [8:0] base;
    case (mp)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd61;
      4'd3:    base = 9'd92;
      4'd4:    base = 9'd122;
      4'd5:    base = 9'd153;
      4'd6:    base = 9'd184;
      4'd7:    base = 9'd214;
      4'd8:    base = 9'd245;
      4'd9:    base = 9'd275;
      4'd10:   base = 9'd306;
      4'd11:   base = 9'd337;
      default: base = 9'd0;
    endcase
    return base;
  endfunction

endpackage

// ===== rtl/core/iso2ep_ctrl.sv =====
// Sequencer for the timestamp converter: parse phase, conversion steps, result hand-off.
// Depends on iso2ep_pkg.
module iso2ep_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_char_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output iso2ep_pkg::cmd_t  cmd_o
);
  import iso2ep_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // State and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_PARSE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_PARSE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (last_char_i) begin
            cmd_o.load = 1'b1;
            state_d    = ST_ERA;
          end
        end
      end
      ST_ERA: begin
        cmd_o.era = 1'b1;
        state_d   = ST_YOE;
      end
      ST_YOE: begin
        cmd_o.yoe = 1'b1;
        state_d   = ST_DOE;
      end
      ST_DOE: begin
        cmd_o.doe = 1'b1;
        state_d   = ST_DAYS;
      end
      ST_DAYS: begin
        cmd_o.days = 1'b1;
        state_d    = ST_TOTAL;
      end
      ST_TOTAL: begin
        cmd_o.total = 1'b1;
        state_d     = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_PARSE;
        end
      end
      default: state_d = ST_PARSE;
    endcase
  end

  // Output valid: set on load, cleared once the beat is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/iso2ep_dp.sv =====
// Datapath: character parser, calendar arithmetic and result register.
// Depends on iso2ep_pkg; driven by iso2ep_ctrl commands.
module iso2ep_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  iso2ep_pkg::cmd_t                       cmd_i,
  input  logic [iso2ep_pkg::CharW-1:0]           character_i,
  output logic                                   valid_res_o,
  output logic signed [iso2ep_pkg::EpochW-1:0]   epoch_seconds_o
);
  import iso2ep_pkg::*;

  // Parser state
  logic [PosW-1:0]   pos_q, pos_d;
  logic              err_q, err_d;
  logic [YearW-1:0]  yr_q, yr_d;
  logic [FieldW-1:0] mo_q, mo_d, dy_q, dy_d, hr_q, hr_d, mi_q, mi_d, se_q, se_d;

  logic       is_digit;
  logic [3:0] dv;
  logic       ok_d;

  // Latched fields for conversion
  logic              ok_q;
  logic [YearW-1:0]  cy_q;
  logic [3:0]        cm_q;
  logic [4:0]        cd_q, ch_q;
  logic [5:0]        cmi_q;
  logic [5:0]        cs_q;

  // Conversion registers
  logic signed [YearW:0]  yadj_q, yadj_d;
  logic [3:0]             mp_q, mp_d;
  logic signed [5:0]      era_q, era_d;
  logic [26:0]            era_prod;
  logic [8:0]             yoe_q, yoe_d, doy_q, doy_d;
  logic signed [15:0]     yoe_full;
  logic [17:0]            doe_q, doe_d;
  logic [1:0]             cent;
  logic [16:0]            sod_q, sod_d;
  logic signed [23:0]     days_q, days_d;
  logic signed [41:0]     total_full;
  logic [EpochW-1:0]      total_q;

  // Result register
  logic                     vres_q;
  logic signed [EpochW-1:0] epoch_q;

  // Character classification
  assign is_digit = (character_i >= ChZero) && (character_i <= ChNine);
  assign dv       = is_digit ? 4'(character_i - ChZero) : 4'd0;

  // Parser next values for one character beat
  always_comb begin
    pos_d = pos_q;
    err_d = err_q;
    yr_d  = yr_q;
    mo_d  = mo_q;
    dy_d  = dy_q;
    hr_d  = hr_q;
    mi_d  = mi_q;
    se_d  = se_q;
    if (pos_q < FullLen) begin
      pos_d = pos_q + 5'd1;
      case (pos_q) inside
        PosDashY, PosDashM: begin
          if (character_i != ChDash) err_d = 1'b1;
        end
        PosColH, PosColM: begin
          if (character_i != ChColon) err_d = 1'b1;
        end
        PosSep: begin
          if (character_i != ChUpT && character_i != ChLowT && character_i != ChSpace) begin
            err_d = 1'b1;
          end
        end
        default: begin
          if (!is_digit) begin
            err_d = 1'b1;
          end else if (pos_q < PosDashY) begin
            yr_d = 14'(yr_q * 14'd10 + 14'(dv));
          end else if (pos_q < PosDashM) begin
            mo_d = 7'(mo_q * 7'd10 + 7'(dv));
          end else if (pos_q < PosSep) begin
            dy_d = 7'(dy_q * 7'd10 + 7'(dv));
          end else if (pos_q < PosColH) begin
            hr_d = 7'(hr_q * 7'd10 + 7'(dv));
          end else if (pos_q < PosColM) begin
            mi_d = 7'(mi_q * 7'd10 + 7'(dv));
          end else begin
            se_d = 7'(se_q * 7'd10 + 7'(dv));
          end
        end
      endcase
    end
  end

  // Form and range check on the final character
  assign ok_d = (pos_d >= FullLen) && !err_d
             && (mo_d >= 7'd1) && (mo_d <= 7'd12)
             && (dy_d >= 7'd1) && (dy_d <= 7'd31)
             && (hr_d <= 7'd23) && (mi_d <= 7'd59) && (se_d <= 7'd60);

  // Parser registers: cleared after the final character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      err_q <= 1'b0;
      yr_q  <= '0;
      mo_q  <= '0;
      dy_q  <= '0;
      hr_q  <= '0;
      mi_q  <= '0;
      se_q  <= '0;
    end else if (cmd_i.load) begin
      pos_q <= '0;
      err_q <= 1'b0;
      yr_q  <= '0;
      mo_q  <= '0;
      dy_q  <= '0;
      hr_q  <= '0;
      mi_q  <= '0;
      se_q  <= '0;
    end else if (cmd_i.take) begin
      pos_q <= pos_d;
      err_q <= err_d;
      yr_q  <= yr_d;
      mo_q  <= mo_d;
      dy_q  <= dy_d;
      hr_q  <= hr_d;
      mi_q  <= mi_d;
      se_q  <= se_d;
    end
  end

  // Latch fields; values only matter when the check passed
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ok_q  <= ok_d;
      cy_q  <= yr_d;
      cm_q  <= mo_d[3:0];
      cd_q  <= dy_d[4:0];
      ch_q  <= hr_d[4:0];
      cmi_q <= mi_d[5:0];
      cs_q  <= se_d[5:0];
    end
  end

  // Step 1: March-based year and month, era = floor(y / 400)
  assign yadj_d   = $signed({1'b0, cy_q}) - ((cm_q <= 4'd2) ? 15'sd1 : 15'sd0);
  assign mp_d     = (cm_q > 4'd2) ? (cm_q - 4'd3) : (cm_q + 4'd9);
  assign era_prod = 27'(yadj_d[YearW-1:0]) * 27'(EraRecip);
  assign era_d    = yadj_d[YearW] ? -6'sd1 : $signed(6'(era_prod >> EraShift));

  // Step 2: year of era, day of year
  assign yoe_full = 16'(yadj_q) - (16'(era_q) * 16'sd400);
  assign yoe_d    = yoe_full[8:0];
  assign doy_d    = month_base(mp_q) + 9'(cd_q) - 9'd1;

  // Step 3: day of era and second of day
  assign cent  = (yoe_q >= 9'd300) ? 2'd3 : (yoe_q >= 9'd200) ? 2'd2 :
                 (yoe_q >= 9'd100) ? 2'd1 : 2'd0;
  assign doe_d = 18'(yoe_q) * 18'd365 + 18'(yoe_q >> 2) - 18'(cent) + 18'(doy_q);
  assign sod_d = 17'(ch_q) * 17'd3600 + 17'(cmi_q) * 17'd60 + 17'(cs_q);

  // Step 4: days since 1970
  assign days_d = 24'(era_q) * 24'sd146097 + $signed({6'b0, doe_q}) - 24'sd719468;

  // Step 5: seconds since 1970
  assign total_full = 42'(days_q) * 42'sd86400 + $signed({25'b0, sod_q});

  // Conversion step registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.era) begin
      yadj_q <= yadj_d;
      mp_q   <= mp_d;
      era_q  <= era_d;
    end
    if (cmd_i.yoe) begin
      yoe_q <= yoe_d;
      doy_q <= doy_d;
    end
    if (cmd_i.doe) begin
      doe_q <= doe_d;
      sod_q <= sod_d;
    end
    if (cmd_i.days) begin
      days_q <= days_d;
    end
    if (cmd_i.total) begin
      total_q <= total_full[EpochW-1:0];
    end
  end

  // Result register; zero seconds when the text was rejected
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      vres_q  <= ok_q;
      epoch_q <= ok_q ? $signed(total_q) : '0;
    end
  end

  assign valid_res_o     = vres_q;
  assign epoch_seconds_o = epoch_q;

endmodule

// ===== rtl/core/iso_timestamp_to_epoch_seconds.sv =====
// Top level of the ISO timestamp to epoch seconds converter.
// Depends on iso2ep_pkg, iso2ep_ctrl and iso2ep_dp.
//
// Takes YYYY-MM-DDTHH:MM:SS text one character per beat, last_char_i marking the
// final character, and returns one result beat per string: valid_res_o and signed
// UTC seconds since 1970 (zero when the text is malformed, short or out of range;
// characters past the nineteenth are ignored, second 60 is accepted and the day is
// not checked against month length). Characters are taken one per cycle. After the
// final character the input stalls while the controller walks the datapath through
// the calendar steps (era, year of era, day of era, days, seconds, result load); the
// stall is longer if the previous result has not yet been taken. A pending result
// sits in its own output register, so the next string may start while the receiver
// is still stalling.
module iso_timestamp_to_epoch_seconds (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [iso2ep_pkg::CharW-1:0]         character_i,
  input  logic                                 last_char_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 valid_res_o,
  output logic signed [iso2ep_pkg::EpochW-1:0] epoch_seconds_o
);
  import iso2ep_pkg::*;

  cmd_t cmd;

  // Sequencer
  iso2ep_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_char_i (last_char_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Parser and calendar datapath
  iso2ep_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .character_i     (character_i),
    .valid_res_o     (valid_res_o),
    .epoch_seconds_o (epoch_seconds_o)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for iso_timestamp_to_epoch_seconds: streams timestamp text
// one character per beat and checks each result beat against an in-bench calendar.
// Depends on iso2ep_pkg and the RTL top level only.
module tb_top;
  import iso2ep_pkg::*;

  localparam int unsigned RandomBeats   = 625;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned TailCycles    = 20;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             fin;
  } char_beat_t;

  typedef struct packed {
    logic                     ok;
    logic signed [EpochW-1:0] secs;
  } epoch_result_t;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CharW-1:0]         character = '0;
  logic                     last_char = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     valid_res;
  logic signed [EpochW-1:0] epoch_seconds;

  iso_timestamp_to_epoch_seconds u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .character_i     (character),
    .last_char_i     (last_char),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .valid_res_o     (valid_res),
    .epoch_seconds_o (epoch_seconds)
  );

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  char_beat_t    char_q[$];
  epoch_result_t epoch_q[$];
  logic [7:0]    txt[$];
  int unsigned   beats_in;
  int unsigned   results_seen;
  int unsigned   hold_left;
  int unsigned   stuck_cycles;
  int unsigned   fail_count;
  logic          held_once;

  // Parser state mirrored in the bench
  logic [PosW-1:0]   cur_pos;
  logic              fmt_bad;
  logic [YearW-1:0]  acc_year;
  logic [FieldW-1:0] acc_month, acc_day, acc_hour, acc_min, acc_sec;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_parser();
    cur_pos   = '0;
    fmt_bad   = 1'b0;
    acc_year  = '0;
    acc_month = '0;
    acc_day   = '0;
    acc_hour  = '0;
    acc_min   = '0;
    acc_sec   = '0;
  endfunction

  // Proleptic Gregorian day count relative to 1970-01-01, March-based year
  function automatic longint days_since_1970(longint y, longint m, longint d);
    longint era, yoe, doy, doe;
    if (m <= 2) y = y - 1;
    era = (y >= 0 ? y : y - 399) / 400;
    yoe = y - era * 400;
    doy = (153 * (m + (m > 2 ? -3 : 9)) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  // Feed one accepted character beat; on the final one queue the expected result
  function automatic void parse_char(input logic [CharW-1:0] ch, input logic fin);
    logic          is_dig;
    logic [7:0]    dv;
    longint        total;
    epoch_result_t res;
    is_dig = (ch >= ChZero) && (ch <= ChNine);
    dv     = ch - ChZero;
    if (cur_pos < FullLen) begin
      if (cur_pos == PosDashY || cur_pos == PosDashM) begin
        if (ch != ChDash) fmt_bad = 1'b1;
      end else if (cur_pos == PosColH || cur_pos == PosColM) begin
        if (ch != ChColon) fmt_bad = 1'b1;
      end else if (cur_pos == PosSep) begin
        if (ch != ChUpT && ch != ChLowT && ch != ChSpace) fmt_bad = 1'b1;
      end else if (!is_dig) begin
        fmt_bad = 1'b1;
      end else if (cur_pos < PosDashY) begin
        acc_year = YearW'(acc_year * 10 + dv);
      end else if (cur_pos < PosDashM) begin
        acc_month = FieldW'(acc_month * 10 + dv);
      end else if (cur_pos < PosSep) begin
        acc_day = FieldW'(acc_day * 10 + dv);
      end else if (cur_pos < PosColH) begin
        acc_hour = FieldW'(acc_hour * 10 + dv);
      end else if (cur_pos < PosColM) begin
        acc_min = FieldW'(acc_min * 10 + dv);
      end else begin
        acc_sec = FieldW'(acc_sec * 10 + dv);
      end
      cur_pos = cur_pos + 1'b1;
    end
    if (fin) begin
      res.ok = (cur_pos >= FullLen) && !fmt_bad
            && acc_month >= 1 && acc_month <= 12 && acc_day >= 1 && acc_day <= 31
            && acc_hour <= 23 && acc_min <= 59 && acc_sec <= 60;
      res.secs = '0;
      if (res.ok) begin
        total = days_since_1970(longint'(acc_year), longint'(acc_month),
                                longint'(acc_day)) * 86400
              + longint'(acc_hour) * 3600 + longint'(acc_min) * 60 + longint'(acc_sec);
        res.secs = total[EpochW-1:0];
      end
      epoch_q.push_back(res);
      clear_parser();
    end
  endfunction

  // Text assembly: scratch buffer, then moved to the beat queue
  task automatic load_text(input string s);
    txt.delete();
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
  endtask

  task automatic commit_text();
    char_beat_t b;
    for (int i = 0; i < txt.size(); i++) begin
      b.ch  = txt[i];
      b.fin = (i == txt.size() - 1);
      char_q.push_back(b);
    end
  endtask

  task automatic send_str(input string s);
    load_text(s);
    commit_text();
  endtask

  // Mostly well-formed timestamps; the rest corrupted, truncated or noise
  task automatic queue_random_stamp();
    int unsigned kind, yr, mo, dy, hh, mi, ss;
    logic [7:0]  sep;
    kind = $urandom_range(0, 99);
    yr   = $urandom_range(0, 9999);
    mo   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
    dy   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
    hh   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
    mi   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
    ss   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 60);
    case ($urandom_range(0, 2))
      0:       sep = ChUpT;
      1:       sep = ChLowT;
      default: sep = ChSpace;
    endcase
    load_text($sformatf("%04d-%02d-%02d%c%02d:%02d:%02d", yr, mo, dy, sep, hh, mi, ss));
    if (kind < 70) begin
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 4)) txt.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 80) begin
      txt[$urandom_range(0, 18)] = 8'($urandom_range(0, 255));
    end else if (kind < 90) begin
      txt = txt[0:$urandom_range(0, 17)];
    end else begin
      txt.delete();
      repeat ($urandom_range(1, 25)) txt.push_back(8'($urandom_range(0, 255)));
    end
    commit_text();
  endtask

  // Sender: holds each beat until taken, idles at random outside a quiet window
  always @(posedge clk or negedge rst_n) begin : drv
    char_beat_t nxt;
    logic       idle;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      character <= '0;
      last_char <= 1'b0;
      beats_in  <= 0;
    end else begin
      if (in_fire) begin
        parse_char(character, last_char);
        beats_in <= beats_in + 1;
      end
      if (!in_valid || !in_stall) begin
        idle = (beats_in < 300 || beats_in >= 600) && ($urandom_range(0, 99) < 16);
        if (char_q.size() != 0 && !idle) begin
          nxt = char_q.pop_front();
          in_valid  <= 1'b1;
          character <= nxt.ch;
          last_char <= nxt.fin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result beat, stalls at random outside a no-stall window, one long hold-off
  always @(posedge clk or negedge rst_n) begin : mon
    epoch_result_t want;
    if (!rst_n) begin
      out_stall    <= 1'b0;
      results_seen <= 0;
      hold_left    <= 0;
      held_once    <= 1'b0;
    end else begin
      if (out_fire) begin
        if (epoch_q.size() == 0) begin
          $error("unexpected result beat: valid_res=%0b epoch_seconds=%0d",
                 valid_res, epoch_seconds);
          fail_count++;
        end else begin
          want = epoch_q.pop_front();
          if (valid_res !== want.ok) begin
            $error("valid_res: expected %0b, got %0b", want.ok, valid_res);
            fail_count++;
          end
          if (epoch_seconds !== want.secs) begin
            $error("epoch_seconds: expected %0d, got %0d", want.secs, epoch_seconds);
            fail_count++;
          end
        end
        results_seen <= results_seen + 1;
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (results_seen == 12 && !held_once) begin
        held_once <= 1'b1;
        hold_left <= HoldOffCycles;
        out_stall <= 1'b1;
      end else if (results_seen >= 20 && results_seen < 40) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 16);
      end
    end
  end

  // Watchdog on cycles without any beat accepted
  always @(posedge clk) begin
    if (!rst_n || in_fire || out_fire) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stim
    int unsigned n_directed;
    fail_count = 0;
    clear_parser();

    // Directed: field extremes, separators, range limits, malformed text
    send_str("1970-01-01T00:00:00");
    send_str("0000-01-01T00:00:00");
    send_str("9999-12-31T23:59:60");
    send_str("2000-02-29t12:34:56");
    send_str("2024-03-01 00:00:00");
    send_str("2021-02-31T10:00:00");   // rolls into March
    send_str("2023-00-10T00:00:00");
    send_str("2023-13-10T00:00:00");
    send_str("2023-05-00T00:00:00");
    send_str("2023-05-32T00:00:00");
    send_str("2023-05-10T24:00:00");
    send_str("2023-05-10T23:60:00");
    send_str("2023-05-10T23:59:61");
    send_str("2023-05-10X23:59:59");
    send_str("2023/05-10T23:59:59");
    send_str("2023-05-10T23.59:59");
    send_str("20a3-05-10T23:59:59");
    send_str("2023-05-10T23:59");      // short
    send_str("9");
    send_str("2023-05-10T23:59:59Z+01:00");
    // all-ones and all-zero bytes, inside the text and trailing
    load_text("1999-12-31T23:59:59");
    txt[3] = 8'hFF;
    commit_text();
    load_text("1999-12-31T23:59:59");
    txt[0] = 8'h00;
    commit_text();
    load_text("2001-09-09T01:46:40");
    txt.push_back(8'h00);
    txt.push_back(8'hFF);
    commit_text();
    n_directed = char_q.size();

    while (char_q.size() < n_directed + RandomBeats) queue_random_stamp();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Sample between edges so that the last accepted beat is already counted
    while (char_q.size() != 0 || in_valid || epoch_q.size() != 0) @(negedge clk);
    repeat (TailCycles) @(posedge clk);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
